// ===== rtl/mcr_pkg.sv =====
// Shared types and constants of the midpoint circle rasteriser.
package mcr_pkg;

	localparam int unsigned RADIUS_MAX = 1023;

	localparam int unsigned RADIUS_W = 10;
	localparam int unsigned COORD_W  = 11;
	localparam int unsigned STEP_W   = 12;
	localparam int unsigned ERR_W    = 13;
	localparam int unsigned IDX_W    = 3;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic FUNC_START    = 1'b0;
	localparam logic FUNC_CONTINUE = 1'b1;

	localparam logic [IDX_W-1:0] LAST_SPAN_IDX  = 3'd3;
	localparam logic [IDX_W-1:0] LAST_POINT_IDX = 3'd7;

	typedef struct packed {
		logic                func;
		logic [RADIUS_W-1:0] radius;
		logic                disk_mode;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] x_start;
		logic [COORD_W-1:0] y_start;
		logic [COORD_W-1:0] x_end;
		logic [COORD_W-1:0] y_end;
		logic               is_span;
		logic               last_of_group;
		logic               circle_done;
	} result_t;

	typedef struct packed {
		logic [RADIUS_W-1:0] centre;
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
		logic                disk;
		logic                done;
	} group_t;

endpackage

// ===== rtl/midpoint_circle_rasterizer_unit.sv =====
// Midpoint circle rasteriser top level: front end, group queue and emitter.
// Each group passes a queue slot and the emitter's group register before reaching the output.
// Outline groups give 8 point beats, disk groups 4 span beats, one per cycle unless stalled.
// The front end takes an item every cycle while the two-entry group queue has room.
// Reset: arst_n clears the active circle, the queue, the emitter busy flag and the output valid.
module midpoint_circle_rasterizer_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  mcr_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output mcr_pkg::result_t result
);

	logic            push;
	logic            pop;
	logic            queue_full;
	logic            queue_not_empty;
	mcr_pkg::group_t group_in;
	mcr_pkg::group_t group_head;

	mcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.queue_full (queue_full),
		.item_stall (item_stall),
		.push       (push),
		.group      (group_in)
	);

	mcr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (group_in),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.head      (group_head)
	);

	mcr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.queue_not_empty (queue_not_empty),
		.head            (group_head),
		.pop             (pop),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result          (result)
	);

`ifndef SYNTHESIS
	a_done_ends_group: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.circle_done |-> result.last_of_group)
		else $error("circle end not on last beat of group");

	a_point_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.is_span |->
			(result.x_end == result.x_start) && (result.y_end == result.y_start))
		else $error("point beat with differing ends");

	a_span_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_span |-> result.y_end == result.y_start)
		else $error("span beat not horizontal");
`endif

endmodule

// ===== rtl/mcr_front.sv =====
// Front end: accepts items, runs the midpoint walk and issues at most one group per item.
module mcr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  mcr_pkg::item_t    item,
	input  logic              queue_full,
	output logic              item_stall,
	output logic              push,
	output mcr_pkg::group_t   group
);

	logic                         active_q;
	logic [mcr_pkg::RADIUS_W-1:0] centre_q;
	logic                         disk_q;
	logic [mcr_pkg::COORD_W-1:0]  x_q;
	logic [mcr_pkg::COORD_W-1:0]  y_q;
	logic [mcr_pkg::STEP_W-1:0]   tx_q;
	logic [mcr_pkg::STEP_W-1:0]   ty_q;
	logic [mcr_pkg::ERR_W-1:0]    err_q;

	logic                         accept;
	logic                         start;
	logic [mcr_pkg::RADIUS_W-1:0] radius_sat;
	logic                         emit;
	logic [mcr_pkg::RADIUS_W-1:0] c;
	logic                         disk;
	logic [mcr_pkg::COORD_W-1:0]  x;
	logic [mcr_pkg::COORD_W-1:0]  y;
	logic [mcr_pkg::STEP_W-1:0]   tx;
	logic [mcr_pkg::STEP_W-1:0]   ty;
	logic [mcr_pkg::ERR_W-1:0]    err;
	logic                         step_y;
	logic                         step_x;
	logic [mcr_pkg::ERR_W-1:0]    err1;
	logic [mcr_pkg::ERR_W-1:0]    err2;
	logic [mcr_pkg::STEP_W-1:0]   tx1;
	logic [mcr_pkg::STEP_W-1:0]   ty1;
	logic [mcr_pkg::COORD_W-1:0]  x1;
	logic [mcr_pkg::COORD_W-1:0]  y1;
	logic                         done;

	assign item_stall = queue_full;
	assign accept     = item_valid && !item_stall;
	assign start      = (item.func == mcr_pkg::FUNC_START);

	always_comb begin
		if (item.radius > mcr_pkg::RADIUS_MAX[mcr_pkg::RADIUS_W-1:0]) begin
			radius_sat = mcr_pkg::RADIUS_MAX[mcr_pkg::RADIUS_W-1:0];
		end else begin
			radius_sat = item.radius;
		end
	end

	always_comb begin
		if (start) begin
			emit = (radius_sat != '0);
			c    = radius_sat;
			disk = item.disk_mode;
			x    = {1'b0, radius_sat} - 11'd1;
			y    = '0;
			tx   = 12'd1;
			ty   = 12'd1;
			err  = 13'd1 - {2'b00, radius_sat, 1'b0};
		end else begin
			emit = active_q;
			c    = centre_q;
			disk = disk_q;
			x    = x_q;
			y    = y_q;
			tx   = tx_q;
			ty   = ty_q;
			err  = err_q;
		end
	end

	// Advance the walk: row step first, then column step on the updated error.
	always_comb begin
		step_y = err[mcr_pkg::ERR_W-1] || (err == '0);
		err1   = step_y ? err + {1'b0, ty} : err;
		ty1    = step_y ? ty + 12'd2 : ty;
		y1     = step_y ? y + 11'd1 : y;
		step_x = !err1[mcr_pkg::ERR_W-1] && (err1 != '0);
		tx1    = step_x ? tx + 12'd2 : tx;
		x1     = step_x ? x - 11'd1 : x;
		err2   = step_x ? err1 + {1'b0, tx1} - {2'b00, c, 1'b0} : err1;
		done   = (x1 < y1);
	end

	assign push         = accept && emit;
	assign group.centre = c;
	assign group.x      = x;
	assign group.y      = y;
	assign group.disk   = disk;
	assign group.done   = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (accept) begin
			if (emit) begin
				active_q <= !done;
			end else if (start) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			centre_q <= c;
			disk_q   <= disk;
			x_q      <= x1;
			y_q      <= y1;
			tx_q     <= tx1;
			ty_q     <= ty1;
			err_q    <= err2;
		end
	end

endmodule

// ===== rtl/mcr_queue.sv =====
// Short group queue between the front end and the emitter.
module mcr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mcr_pkg::group_t push_data,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output mcr_pkg::group_t head
);

	mcr_pkg::group_t             slot_q [mcr_pkg::QUEUE_DEPTH];
	logic [mcr_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [mcr_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [mcr_pkg::QCNT_W-1:0]  count_q;

	assign full      = (count_q == mcr_pkg::QCNT_W'(mcr_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/mcr_back.sv =====
// Back end: expands each group into points or spans, one beat per cycle while the output is not stalled.
module mcr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              queue_not_empty,
	input  mcr_pkg::group_t   head,
	output logic              pop,
	output logic              result_valid,
	input  logic              result_stall,
	output mcr_pkg::result_t  result
);

	logic                        busy_q;
	mcr_pkg::group_t             group_q;
	logic [mcr_pkg::IDX_W-1:0]   idx_q;
	logic                        res_valid_q;
	mcr_pkg::result_t            res_q;

	logic                        adv;
	logic                        last;
	logic [mcr_pkg::COORD_W-1:0] cx;
	logic [mcr_pkg::COORD_W-1:0] c_px;
	logic [mcr_pkg::COORD_W-1:0] c_mx;
	logic [mcr_pkg::COORD_W-1:0] c_py;
	logic [mcr_pkg::COORD_W-1:0] c_my;
	mcr_pkg::result_t            next;

	assign adv  = busy_q && (!res_valid_q || !result_stall);
	assign last = (idx_q == (group_q.disk ? mcr_pkg::LAST_SPAN_IDX : mcr_pkg::LAST_POINT_IDX));
	assign pop  = queue_not_empty && (!busy_q || (adv && last));

	assign cx   = {1'b0, group_q.centre};
	assign c_px = cx + group_q.x;
	assign c_mx = cx - group_q.x;
	assign c_py = cx + group_q.y;
	assign c_my = cx - group_q.y;

	always_comb begin
		next               = '0;
		next.is_span       = group_q.disk;
		next.last_of_group = last;
		next.circle_done   = last && group_q.done;
		if (group_q.disk) begin
			case (idx_q)
				3'd0: begin
					next.x_start = c_px; next.y_start = c_my;
					next.x_end   = c_mx; next.y_end   = c_my;
				end
				3'd1: begin
					next.x_start = c_px; next.y_start = c_py;
					next.x_end   = c_mx; next.y_end   = c_py;
				end
				3'd2: begin
					next.x_start = c_py; next.y_start = c_mx;
					next.x_end   = c_my; next.y_end   = c_mx;
				end
				default: begin
					next.x_start = c_py; next.y_start = c_px;
					next.x_end   = c_my; next.y_end   = c_px;
				end
			endcase
		end else begin
			case (idx_q)
				3'd0: begin next.x_start = c_px; next.y_start = c_my; end
				3'd1: begin next.x_start = c_px; next.y_start = c_py; end
				3'd2: begin next.x_start = c_mx; next.y_start = c_my; end
				3'd3: begin next.x_start = c_mx; next.y_start = c_py; end
				3'd4: begin next.x_start = c_py; next.y_start = c_mx; end
				3'd5: begin next.x_start = c_py; next.y_start = c_px; end
				3'd6: begin next.x_start = c_my; next.y_start = c_mx; end
				default: begin next.x_start = c_my; next.y_start = c_px; end
			endcase
			next.x_end = next.x_start;
			next.y_end = next.y_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (adv && last) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			group_q <= head;
			idx_q   <= '0;
		end else if (adv) begin
			idx_q <= idx_q + 1'b1;
		end
		if (adv) begin
			res_q <= next;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ===== tb/sv/tb_midpoint_circle_rasterizer_unit.sv =====
// Self-checking testbench of the midpoint circle rasteriser: directed table, then random circles.
module tb_midpoint_circle_rasterizer_unit;
	import mcr_pkg::*;

	typedef struct {
		item_t       stim;
		bit          typed;
		int unsigned typed_n;
		result_t     typed_first;
	} stim_row_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	int          walk_x;
	int          walk_y;
	int          term_tx;
	int          term_ty;
	int          walk_err;
	int unsigned centre;
	bit          disk_on;
	bit          circle_live;

	result_t     group_beats[$];
	result_t     expected_beats[$];
	int unsigned mismatches = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_requests = 0;
	int unsigned hold_served;
	int unsigned hold_left;
	int unsigned live_items;

	midpoint_circle_rasterizer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("midpoint_circle_rasterizer_unit verification failed");
		$finish;
	end

	function automatic result_t make_beat(int xs, int ys, int xe, int ye, bit span);
		result_t b;
		b.x_start       = xs[COORD_W-1:0];
		b.y_start       = ys[COORD_W-1:0];
		b.x_end         = xe[COORD_W-1:0];
		b.y_end         = ye[COORD_W-1:0];
		b.is_span       = span;
		b.last_of_group = 1'b0;
		b.circle_done   = 1'b0;
		return b;
	endfunction

	function automatic string beat_text(result_t b);
		return $sformatf("(%0d,%0d)-(%0d,%0d) span=%0b last=%0b done=%0b", b.x_start,
			b.y_start, b.x_end, b.y_end, b.is_span, b.last_of_group, b.circle_done);
	endfunction

	task automatic note_mismatch(string what, result_t want, result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch at %0t: %s", $realtime, what);
			$display("  expected %s", beat_text(want));
			$display("  actual   %s", beat_text(got));
		end
	endtask

	function automatic void rasterise_item(item_t it);
		int      c;
		result_t tail;
		group_beats.delete();
		if (it.func == FUNC_START) begin
			circle_live = 1'b0;
			if (it.radius == 0)
				return;
			centre      = 32'(it.radius);
			disk_on     = it.disk_mode;
			walk_x      = int'(it.radius) - 1;
			walk_y      = 0;
			term_tx     = 1;
			term_ty     = 1;
			walk_err    = 1 - 2 * int'(it.radius);
			circle_live = 1'b1;
		end else if (!circle_live) begin
			return;
		end
		c = int'(centre);
		if (disk_on) begin
			group_beats.push_back(make_beat(c + walk_x, c - walk_y, c - walk_x, c - walk_y, 1'b1));
			group_beats.push_back(make_beat(c + walk_x, c + walk_y, c - walk_x, c + walk_y, 1'b1));
			group_beats.push_back(make_beat(c + walk_y, c - walk_x, c - walk_y, c - walk_x, 1'b1));
			group_beats.push_back(make_beat(c + walk_y, c + walk_x, c - walk_y, c + walk_x, 1'b1));
		end else begin
			group_beats.push_back(make_beat(c + walk_x, c - walk_y, c + walk_x, c - walk_y, 1'b0));
			group_beats.push_back(make_beat(c + walk_x, c + walk_y, c + walk_x, c + walk_y, 1'b0));
			group_beats.push_back(make_beat(c - walk_x, c - walk_y, c - walk_x, c - walk_y, 1'b0));
			group_beats.push_back(make_beat(c - walk_x, c + walk_y, c - walk_x, c + walk_y, 1'b0));
			group_beats.push_back(make_beat(c + walk_y, c - walk_x, c + walk_y, c - walk_x, 1'b0));
			group_beats.push_back(make_beat(c + walk_y, c + walk_x, c + walk_y, c + walk_x, 1'b0));
			group_beats.push_back(make_beat(c - walk_y, c - walk_x, c - walk_y, c - walk_x, 1'b0));
			group_beats.push_back(make_beat(c - walk_y, c + walk_x, c - walk_y, c + walk_x, 1'b0));
		end
		if (walk_err <= 0) begin
			walk_y++;
			walk_err += term_ty;
			term_ty  += 2;
		end
		if (walk_err > 0) begin
			walk_x--;
			term_tx  += 2;
			walk_err += term_tx - 2 * c;
		end
		tail = group_beats.pop_back();
		tail.last_of_group = 1'b1;
		if (walk_x < walk_y) begin
			circle_live      = 1'b0;
			tail.circle_done = 1'b1;
		end
		group_beats.push_back(tail);
	endfunction

	function automatic stim_row_t row(logic func, int unsigned radius, logic disk, bit typed = 0,
			int unsigned n = 0, int xs = 0, int ys = 0, int xe = 0, int ye = 0, bit span = 0);
		stim_row_t r;
		r.stim.func      = func;
		r.stim.radius    = radius[RADIUS_W-1:0];
		r.stim.disk_mode = disk;
		r.typed          = typed;
		r.typed_n        = n;
		r.typed_first    = make_beat(xs, ys, xe, ye, span);
		return r;
	endfunction

	task automatic offer(item_t it, bit typed = 0, int unsigned typed_n = 0,
			result_t typed_first = '0);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
		rasterise_item(it);
		if (typed) begin
			if (group_beats.size() != typed_n)
				note_mismatch($sformatf("predicted %0d beats, table gives %0d",
					group_beats.size(), typed_n), '0, '0);
			if (typed_n != 0 && group_beats.size() != 0)
				group_beats[0] = typed_first;
		end
		if (group_beats.size() != 0)
			live_items++;
		foreach (group_beats[i])
			expected_beats.push_back(group_beats[i]);
		@(negedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic draw_circle();
		item_t       it;
		int unsigned sel;
		int unsigned budget;
		sel          = $urandom_range(0, 99);
		it.func      = FUNC_START;
		it.disk_mode = 1'($urandom_range(0, 1));
		budget       = 1000;
		if (sel < 8) begin
			if ($urandom_range(0, 1)) begin
				it.func   = FUNC_CONTINUE;
				it.radius = RADIUS_W'($urandom_range(0, RADIUS_MAX));
			end else begin
				it.radius = '0;
			end
			offer(it);
			return;
		end
		if (sel < 70)
			it.radius = RADIUS_W'($urandom_range(1, 12));
		else if (sel < 92)
			it.radius = RADIUS_W'($urandom_range(13, 60));
		else
			it.radius = RADIUS_W'($urandom_range(61, RADIUS_MAX));
		// abandon large circles early, and break some smaller ones off too
		if (sel >= 92 || $urandom_range(0, 9) == 0)
			budget = $urandom_range(0, 6);
		offer(it);
		while (circle_live && budget != 0) begin
			it.func      = FUNC_CONTINUE;
			it.radius    = RADIUS_W'($urandom_range(0, RADIUS_MAX));
			it.disk_mode = 1'($urandom_range(0, 1));
			offer(it);
			budget--;
		end
		if ($urandom_range(0, 9) == 0) begin
			it.func = FUNC_CONTINUE;
			offer(it);
		end
	endtask

	initial begin
		result_stall = 1'b0;
		hold_served  = 0;
		hold_left    = 0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left   = 300;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : watch
		result_t want;
		string   bad;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_beats.size() == 0) begin
				note_mismatch("beat with nothing expected", '0, result);
			end else begin
				want = expected_beats.pop_front();
				bad  = "";
				if (result.x_start !== want.x_start)             bad = {bad, " x_start"};
				if (result.y_start !== want.y_start)             bad = {bad, " y_start"};
				if (result.x_end !== want.x_end)                 bad = {bad, " x_end"};
				if (result.y_end !== want.y_end)                 bad = {bad, " y_end"};
				if (result.is_span !== want.is_span)             bad = {bad, " is_span"};
				if (result.last_of_group !== want.last_of_group) bad = {bad, " last_of_group"};
				if (result.circle_done !== want.circle_done)     bad = {bad, " circle_done"};
				if (bad != "")
					note_mismatch({"wrong", bad}, want, result);
			end
		end
	end

	initial begin
		stim_row_t   rows[$];
		int unsigned target;
		item_valid  = 1'b0;
		item        = '0;
		arst_n      = 1'b0;
		circle_live = 1'b0;
		live_items  = 0;

		rows.push_back(row(FUNC_CONTINUE, 0, 0, 1, 0));
		rows.push_back(row(FUNC_START, 0, 1, 1, 0));
		rows.push_back(row(FUNC_START, 1, 0, 1, 8, 1, 1, 1, 1, 0));
		rows.push_back(row(FUNC_CONTINUE, 1023, 1, 1, 0));
		rows.push_back(row(FUNC_START, 1, 1, 1, 4, 1, 1, 1, 1, 1));
		rows.push_back(row(FUNC_START, 1023, 0, 1, 8, 2045, 1023, 2045, 1023, 0));
		rows.push_back(row(FUNC_CONTINUE, 0, 0));
		rows.push_back(row(FUNC_CONTINUE, 0, 1));
		rows.push_back(row(FUNC_START, 1023, 1, 1, 4, 2045, 1023, 1, 1023, 1));
		rows.push_back(row(FUNC_CONTINUE, 1023, 0));
		rows.push_back(row(FUNC_START, 0, 0, 1, 0));
		rows.push_back(row(FUNC_CONTINUE, 5, 1, 1, 0));
		rows.push_back(row(FUNC_START, 512, 0, 1, 8, 1023, 512, 1023, 512, 0));
		rows.push_back(row(FUNC_START, 3, 0));
		repeat (3) rows.push_back(row(FUNC_CONTINUE, 0, 0));
		rows.push_back(row(FUNC_START, 6, 1));
		repeat (5) rows.push_back(row(FUNC_CONTINUE, 0, 1));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 20;
		recv_idle_pct = 20;
		foreach (rows[i])
			offer(rows[i].stim, rows[i].typed, rows[i].typed_n, rows[i].typed_first);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 52 : 0;
			recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 36 : 0;
			live_items    = 0;
			target        = 108;
			while (live_items < target) begin
				// hold the output off while items keep coming
				if (phase == 0 && live_items >= 20 && hold_requests == 0)
					hold_requests++;
				draw_circle();
			end
			drain();
		end

		repeat (20) @(negedge clk);
		if (expected_beats.size() != 0)
			note_mismatch("beats never arrived", expected_beats[0], '0);
		if (mismatches == 0) begin
			$display("midpoint_circle_rasterizer_unit verification clean");
		end else begin
			$display("midpoint_circle_rasterizer_unit verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mcr_pkg.sv
rtl/mcr_front.sv
rtl/mcr_queue.sv
rtl/mcr_back.sv
rtl/midpoint_circle_rasterizer_unit.sv
tb/sv/tb_midpoint_circle_rasterizer_unit.sv
